// ----- design/slc_pkg.sv -----
package slc_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_SET_BITS_DEF = 8;
  localparam int unsigned MAX_WAYS_DEF     = 8;
  localparam int unsigned ADDR_BITS_DEF    = 64;

  // Channel payload widths
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned ADDR_W       = 64;
  localparam int unsigned OUTCOME_W    = 2;
  localparam int unsigned CNT_W        = 32;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 8;

  // Configuration register widths
  localparam int unsigned SET_BITS_W   = 4;
  localparam int unsigned BLOCK_BITS_W = 5;
  localparam int unsigned WAYS_W       = 4;
  localparam int unsigned SHIFT_W      = 6;

  // Depth of the queue between front and back
  localparam int unsigned Q_DEPTH      = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_MODIFY = 2'd2
  } cmd_e;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_BITS   = 2'd0,
    REG_BLOCK_BITS = 2'd1,
    REG_WAYS       = 2'd2
  } reg_e;

  typedef struct packed {
    logic [SET_BITS_W-1:0]   set_bits;
    logic [BLOCK_BITS_W-1:0] block_bits;
    logic [WAYS_W-1:0]       ways;
  } cfg_t;

  localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 4'd4;
  localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 5'd4;
  localparam logic [WAYS_W-1:0]       WAYS_RST       = 4'd1;

endpackage

// ----- design/slc_if.sv -----
interface slc_in_if;
  import slc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ADDR_W-1:0] address;
  modport source (output valid, command, address, input ready);
  modport sink (input valid, command, address, output ready);
endinterface

interface slc_out_if;
  import slc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OUTCOME_W-1:0] outcome;
  logic                 store_hit;
  logic [CNT_W-1:0]     hit_total;
  logic [CNT_W-1:0]     miss_total;
  logic [CNT_W-1:0]     evict_total;
  modport source (output valid, outcome, store_hit, hit_total, miss_total, evict_total,
                  input ready);
  modport sink (input valid, outcome, store_hit, hit_total, miss_total, evict_total,
                output ready);
endinterface

interface slc_cfg_if;
  import slc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- design/slc_front.sv -----
module slc_front #(
  parameter int unsigned MAX_SET_BITS = slc_pkg::MAX_SET_BITS_DEF,
  parameter int unsigned ADDR_BITS    = slc_pkg::ADDR_BITS_DEF,
  localparam int unsigned IDX_W       = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  slc_pkg::cfg_t        cfg_i,
  input  logic                 en_i,
  slc_in_if.sink               in_i,
  output logic                 q_valid_o,
  input  logic                 q_pop_i,
  output logic [IDX_W-1:0]     q_set_o,
  output logic [ADDR_BITS-1:0] q_tag_o,
  output logic                 q_modify_o
);
  import slc_pkg::*;

  localparam int unsigned PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  typedef struct packed {
    logic [IDX_W-1:0]     set_idx;
    logic [ADDR_BITS-1:0] tag;
    logic                 modify;
  } entry_t;

  entry_t               q_mem_q [Q_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]       cnt_q, cnt_d;
  logic                 push;
  logic [SET_BITS_W-1:0] set_eff;
  logic [SHIFT_W-1:0]   tag_shift;
  logic [ADDR_BITS-1:0] addr_m;
  logic [ADDR_BITS-1:0] addr_off;
  logic [IDX_W-1:0]     set_mask;
  entry_t               entry;

  // Split the address into set index and tag
  always_comb begin
    set_eff   = (cfg_i.set_bits > SET_BITS_W'(MAX_SET_BITS)) ? SET_BITS_W'(MAX_SET_BITS)
                                                              : cfg_i.set_bits;
    tag_shift = SHIFT_W'(set_eff) + SHIFT_W'(cfg_i.block_bits);
    addr_m    = in_i.address[ADDR_BITS-1:0];
    addr_off  = addr_m >> cfg_i.block_bits;
    set_mask  = ~({IDX_W{1'b1}} << set_eff);
    entry.set_idx = addr_off[IDX_W-1:0] & set_mask;
    entry.tag     = addr_m >> tag_shift;
    entry.modify  = (in_i.command == CMD_MODIFY);
  end

  assign in_i.ready = en_i && (cnt_q != (PTR_W+1)'(Q_DEPTH));
  assign push       = in_i.valid && in_i.ready;
  assign q_valid_o  = (cnt_q != '0);
  assign q_set_o    = q_mem_q[rd_ptr_q].set_idx;
  assign q_tag_o    = q_mem_q[rd_ptr_q].tag;
  assign q_modify_o = q_mem_q[rd_ptr_q].modify;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (q_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= entry;
    end
  end

  a_fill_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !q_pop_i |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not advance on transfer");

endmodule

// ----- design/slc_back.sv -----
module slc_back #(
  parameter int unsigned MAX_SET_BITS = slc_pkg::MAX_SET_BITS_DEF,
  parameter int unsigned MAX_WAYS     = slc_pkg::MAX_WAYS_DEF,
  parameter int unsigned ADDR_BITS    = slc_pkg::ADDR_BITS_DEF,
  localparam int unsigned IDX_W       = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  slc_pkg::cfg_t        cfg_i,
  output logic                 busy_o,
  input  logic                 q_valid_i,
  output logic                 q_pop_o,
  input  logic [IDX_W-1:0]     q_set_i,
  input  logic [ADDR_BITS-1:0] q_tag_i,
  input  logic                 q_modify_i,
  slc_out_if.source            out_o
);
  import slc_pkg::*;

  localparam int unsigned ROWS  = 1 << MAX_SET_BITS;
  localparam int unsigned AGE_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned NW_W  = $clog2(MAX_WAYS + 1);
  localparam logic [AGE_W-1:0] AGE_MAX  = AGE_W'(MAX_WAYS - 1);
  localparam logic [AGE_W:0]   AGE_FREE = (AGE_W+1)'(MAX_WAYS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROWS - 1);

  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] tag;
    logic [AGE_W-1:0]     age;
  } line_t;

  typedef line_t [MAX_WAYS-1:0] row_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] v, logic [1:0] inc);
    logic [CNT_W:0] s;
    s = {1'b0, v} + (CNT_W+1)'(inc);
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  row_t                 mem_q [ROWS];
  row_t                 rd_row_q;
  row_t                 new_row;
  state_e               state_q, state_d;
  logic [IDX_W-1:0]     clr_idx_q;
  logic [IDX_W-1:0]     set_q;
  logic [ADDR_BITS-1:0] tag_q;
  logic                 modify_q;
  logic [CNT_W-1:0]     hit_cnt_q, miss_cnt_q, evict_cnt_q;
  logic                 out_valid_q;
  outcome_e             outcome_q, outcome_d;
  logic                 store_hit_q;
  logic                 rd_en, commit, mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  row_t                 mem_wdata;
  logic [NW_W-1:0]      nways;
  logic [MAX_WAYS-1:0]  in_use;
  logic [MAX_WAYS-1:0]  win_oh;
  logic                 hit_found, free_found;
  logic [WAY_W-1:0]     hit_way, free_way, vic_way, sel_way;
  logic [AGE_W-1:0]     vic_age;
  logic [AGE_W:0]       limit;
  logic [1:0]           hit_inc;

  assign nways = (cfg_i.ways == '0) ? NW_W'(1)
               : ({1'b0, cfg_i.ways} > (WAYS_W+1)'(MAX_WAYS)) ? NW_W'(MAX_WAYS)
               : NW_W'(cfg_i.ways);

  // Look up the set, pick the way and age the others
  always_comb begin
    hit_found  = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      in_use[i] = (NW_W'(i) < nways);
      if (in_use[i] && rd_row_q[i].valid && (rd_row_q[i].tag == tag_q)) begin
        hit_found = 1'b1;
        hit_way   = WAY_W'(i);
      end
      if (in_use[i] && !rd_row_q[i].valid) begin
        free_found = 1'b1;
        free_way   = WAY_W'(i);
      end
    end
    vic_way = '0;
    vic_age = rd_row_q[0].age;
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (in_use[i] && (rd_row_q[i].age > vic_age)) begin
        vic_way = WAY_W'(i);
        vic_age = rd_row_q[i].age;
      end
    end
    priority if (hit_found) begin
      sel_way   = hit_way;
      limit     = {1'b0, rd_row_q[hit_way].age};
      outcome_d = OUT_HIT;
    end else if (free_found) begin
      sel_way   = free_way;
      limit     = AGE_FREE;
      outcome_d = OUT_FILL;
    end else begin
      sel_way   = vic_way;
      limit     = {1'b0, vic_age};
      outcome_d = OUT_EVICT;
    end
    new_row = rd_row_q;
    for (int i = 0; i < MAX_WAYS; i++) begin
      win_oh[i] = (sel_way == WAY_W'(i));
      if (win_oh[i]) begin
        new_row[i].valid = 1'b1;
        new_row[i].tag   = tag_q;
        new_row[i].age   = '0;
      end else if (in_use[i] && rd_row_q[i].valid && ({1'b0, rd_row_q[i].age} < limit)
                   && (rd_row_q[i].age < AGE_MAX)) begin
        new_row[i].age = rd_row_q[i].age + 1'b1;
      end
    end
  end

  assign busy_o    = (state_q == ST_CLEAR);
  assign rd_en     = (state_q == ST_IDLE) && q_valid_i;
  assign q_pop_o   = rd_en;
  assign commit    = (state_q == ST_EXEC) && (!out_valid_q || out_o.ready);
  assign mem_we    = busy_o || commit;
  assign mem_waddr = busy_o ? clr_idx_q : set_q;
  assign mem_wdata = busy_o ? '0 : new_row;
  assign hit_inc   = {1'b0, (outcome_d == OUT_HIT)} + {1'b0, modify_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_idx_q == LAST_IDX) state_d = ST_IDLE;
      ST_IDLE:  if (q_valid_i) state_d = ST_EXEC;
      ST_EXEC:  if (commit) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      evict_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (busy_o) begin
        clr_idx_q <= clr_idx_q + 1'b1;
      end
      if (commit) begin
        hit_cnt_q   <= sat_add(hit_cnt_q, hit_inc);
        miss_cnt_q  <= sat_add(miss_cnt_q, {1'b0, (outcome_d != OUT_HIT)});
        evict_cnt_q <= sat_add(evict_cnt_q, {1'b0, (outcome_d == OUT_EVICT)});
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Tag RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_row_q <= mem_q[q_set_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      set_q    <= q_set_i;
      tag_q    <= q_tag_i;
      modify_q <= q_modify_i;
    end
    if (commit) begin
      outcome_q   <= outcome_d;
      store_hit_q <= modify_q;
    end
  end

  // Counters double as the result totals
  assign out_o.valid       = out_valid_q;
  assign out_o.outcome     = outcome_q;
  assign out_o.store_hit   = store_hit_q;
  assign out_o.hit_total   = hit_cnt_q;
  assign out_o.miss_total  = miss_cnt_q;
  assign out_o.evict_total = evict_cnt_q;

  a_evict_le_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evict_cnt_q <= miss_cnt_q)
    else $error("eviction count exceeds miss count");

  a_one_way: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> $onehot(win_oh))
    else $error("update does not select exactly one way");

  a_miss_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && (outcome_d != OUT_HIT) && (miss_cnt_q != {CNT_W{1'b1}})
    |=> miss_cnt_q == $past(miss_cnt_q) + 1'b1)
    else $error("miss not counted");

  a_totals_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> $stable(hit_cnt_q) && $stable(evict_cnt_q))
    else $error("totals changed under a stalled result");

endmodule

// ----- design/set_assoc_lru_cache_sim_top.sv -----
// Channel  Dir  Modport  Payload
// cfg_i    in   sink     index, data (set_bits, block_bits, ways)
// in_i     in   sink     command, address
// out_o    out  source   outcome, store_hit, hit_total, miss_total, evict_total
//
// In the lookup engine an access first reads the set's row from the tag RAM, then
// compares tags, updates ages and writes the row back.
// After reset a sweep clears all 2**MAX_SET_BITS rows of the tag RAM (256 by default);
// in_i.ready stays low during the sweep, cfg_i writes are taken throughout.
// A 2-entry queue holds decoded accesses while the engine is busy; a stalled
// out_o holds the engine in its compare cycle with the result in the output register.
module set_assoc_lru_cache_sim_top #(
  parameter int unsigned MAX_SET_BITS = slc_pkg::MAX_SET_BITS_DEF,
  parameter int unsigned MAX_WAYS     = slc_pkg::MAX_WAYS_DEF,
  parameter int unsigned ADDR_BITS    = slc_pkg::ADDR_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  slc_cfg_if.sink   cfg_i,
  slc_in_if.sink    in_i,
  slc_out_if.source out_o
);
  import slc_pkg::*;

  localparam int unsigned IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

  cfg_t                 cfg_q;
  logic                 busy;
  logic                 q_valid, q_pop, q_modify;
  logic [IDX_W-1:0]     q_set;
  logic [ADDR_BITS-1:0] q_tag;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.set_bits   <= SET_BITS_RST;
      cfg_q.block_bits <= BLOCK_BITS_RST;
      cfg_q.ways       <= WAYS_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_SET_BITS:   cfg_q.set_bits   <= cfg_i.data[SET_BITS_W-1:0];
        REG_BLOCK_BITS: cfg_q.block_bits <= cfg_i.data[BLOCK_BITS_W-1:0];
        REG_WAYS:       cfg_q.ways       <= cfg_i.data[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  slc_front #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .ADDR_BITS    (ADDR_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .en_i       (!busy),
    .in_i       (in_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_set_o    (q_set),
    .q_tag_o    (q_tag),
    .q_modify_o (q_modify)
  );

  slc_back #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_BITS    (ADDR_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .busy_o     (busy),
    .q_valid_i  (q_valid),
    .q_pop_o    (q_pop),
    .q_set_i    (q_set),
    .q_tag_i    (q_tag),
    .q_modify_i (q_modify),
    .out_o      (out_o)
  );

endmodule

// ----- bench/slc_checker.sv -----
`timescale 1ns / 100ps

module slc_checker #(
  parameter int unsigned MAX_SET_BITS = slc_pkg::MAX_SET_BITS_DEF,
  parameter int unsigned MAX_WAYS     = slc_pkg::MAX_WAYS_DEF,
  parameter int unsigned ADDR_BITS    = slc_pkg::ADDR_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  slc_cfg_if          cfg_i,
  slc_in_if           acc_i,
  slc_out_if          res_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);
  import slc_pkg::*;

  localparam int unsigned NUM_LINES = (1 << MAX_SET_BITS) * MAX_WAYS;
  localparam int unsigned AGE_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned AGE_TOP   = MAX_WAYS - 1;
  localparam logic [ADDR_W-1:0] ADDR_MASK =
    (ADDR_BITS >= ADDR_W) ? '1 : ((ADDR_W'(1) << ADDR_BITS) - 1);

  typedef struct packed {
    outcome_e         outcome;
    logic             store_hit;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] evictions;
  } access_result_t;

  logic [SET_BITS_W-1:0]   set_bits_q;
  logic [BLOCK_BITS_W-1:0] block_bits_q;
  logic [WAYS_W-1:0]       ways_q;

  logic              line_valid [NUM_LINES];
  logic [ADDR_W-1:0] line_tag   [NUM_LINES];
  logic [AGE_W-1:0]  line_age   [NUM_LINES];
  logic [CNT_W-1:0]  hit_cnt, miss_cnt, evict_cnt;

  access_result_t awaited_q[$];
  int unsigned    fail_cnt;

  assign errors_o = fail_cnt;

  function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Make way w the newest; ways younger than limit grow one step older.
  function automatic void age_up(int unsigned base, int unsigned nw, int unsigned w,
                                 int unsigned limit);
    for (int unsigned i = 0; i < nw; i++) begin
      if (i != w && line_valid[base+i] && line_age[base+i] < limit &&
          line_age[base+i] < AGE_TOP) begin
        line_age[base+i] = line_age[base+i] + 1'b1;
      end
    end
    line_age[base+w] = '0;
  endfunction

  function automatic access_result_t lookup_access(logic [CMD_W-1:0] cmd,
                                                   logic [ADDR_W-1:0] addr);
    access_result_t r;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] tag;
    int unsigned s, b, nw, set_idx, sh, base, victim;
    int hit_way;
    int free_way;
    a        = addr & ADDR_MASK;
    s        = (set_bits_q > MAX_SET_BITS) ? MAX_SET_BITS : set_bits_q;
    b        = block_bits_q;
    nw       = (ways_q == 0) ? 1 : ((ways_q > MAX_WAYS) ? MAX_WAYS : ways_q);
    set_idx  = int'((a >> b) & ((ADDR_W'(1) << s) - 1));
    sh       = b + s;
    tag      = (sh >= ADDR_W) ? '0 : (a >> sh);
    base     = set_idx * MAX_WAYS;
    hit_way  = -1;
    free_way = -1;
    for (int unsigned i = 0; i < nw; i++) begin
      if (hit_way < 0 && line_valid[base+i] && line_tag[base+i] == tag) hit_way = i;
      if (free_way < 0 && !line_valid[base+i]) free_way = i;
    end
    r = '0;
    if (hit_way >= 0) begin
      hit_cnt = bump(hit_cnt);
      age_up(base, nw, hit_way, line_age[base+hit_way]);
      r.outcome = OUT_HIT;
    end else if (free_way >= 0) begin
      miss_cnt = bump(miss_cnt);
      line_valid[base+free_way] = 1'b1;
      line_tag[base+free_way]   = tag;
      age_up(base, nw, free_way, AGE_TOP + 1);
      r.outcome = OUT_FILL;
    end else begin
      miss_cnt  = bump(miss_cnt);
      evict_cnt = bump(evict_cnt);
      victim    = 0;
      for (int unsigned i = 1; i < nw; i++) begin
        if (line_age[base+i] > line_age[base+victim]) victim = i;
      end
      line_tag[base+victim] = tag;
      age_up(base, nw, victim, line_age[base+victim]);
      r.outcome = OUT_EVICT;
    end
    if (cmd == CMD_MODIFY) begin
      hit_cnt     = bump(hit_cnt);
      r.store_hit = 1'b1;
    end
    r.hits      = hit_cnt;
    r.misses    = miss_cnt;
    r.evictions = evict_cnt;
    return r;
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      fail_cnt++;
      if (fail_cnt <= 10) begin
        $display("%0t: %s mismatch, expected %0h got %0h", $time, name, want, got);
      end
    end
  endfunction

  function automatic void check_result();
    access_result_t want;
    if (awaited_q.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= 10) begin
        $display("%0t: result with no access pending, outcome %0d hits %0h", $time,
                 res_i.outcome, res_i.hit_total);
      end
    end else begin
      want = awaited_q.pop_front();
      compare_field("outcome", want.outcome, res_i.outcome);
      compare_field("store_hit", want.store_hit, res_i.store_hit);
      compare_field("hit_total", want.hits, res_i.hit_total);
      compare_field("miss_total", want.misses, res_i.miss_total);
      compare_field("evict_total", want.evictions, res_i.evict_total);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   = SET_BITS_RST;
      block_bits_q = BLOCK_BITS_RST;
      ways_q       = WAYS_RST;
      for (int unsigned i = 0; i < NUM_LINES; i++) begin
        line_valid[i] = 1'b0;
        line_tag[i]   = '0;
        line_age[i]   = '0;
      end
      hit_cnt   = '0;
      miss_cnt  = '0;
      evict_cnt = '0;
      awaited_q.delete();
      fail_cnt  = 0;
      pending_o <= 0;
    end else begin
      // a result never belongs to an access taken on the same edge
      if (res_i.valid && res_i.ready) check_result();
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_SET_BITS:   set_bits_q   = cfg_i.data[SET_BITS_W-1:0];
          REG_BLOCK_BITS: block_bits_q = cfg_i.data[BLOCK_BITS_W-1:0];
          REG_WAYS:       ways_q       = cfg_i.data[WAYS_W-1:0];
          default: ;
        endcase
      end
      if (acc_i.valid && acc_i.ready) begin
        awaited_q.push_back(lookup_access(acc_i.command, acc_i.address));
      end
      pending_o <= awaited_q.size();
    end
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import slc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned PHASES         = 12;
  localparam int unsigned PHASE_ITEMS    = 50;
  localparam logic [CMD_W-1:0]     CMD_UNKNOWN = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONE    = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni;

  slc_cfg_if cfg_bus ();
  slc_in_if  acc_bus ();
  slc_out_if res_bus ();

  int unsigned errors;
  int unsigned pending;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned stall_left;
  int unsigned idle_cycles;
  int unsigned cur_set, cur_blk, cur_ways;

  set_assoc_lru_cache_sim_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (acc_bus),
    .out_o  (res_bus)
  );

  slc_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_bus),
    .acc_i     (acc_bus),
    .res_i     (res_bus),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // receiver stalls in random bursts; drop any burst once stalls are off
  always @(posedge clk_i) begin
    if (stall_pct == 0) stall_left = 0;
    else if (stall_left > 0) stall_left--;
    else if ($urandom_range(1, 100) <= stall_pct) stall_left = $urandom_range(1, 18);
    res_bus.ready <= (stall_left == 0);
  end

  always @(posedge clk_i) begin
    if ((acc_bus.valid && acc_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Leaves valid high after the transfer; a sender gap lowers it.
  task automatic send_access(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr);
    acc_bus.valid   <= 1'b1;
    acc_bus.command <= cmd;
    acc_bus.address <= addr;
    do @(posedge clk_i); while (!acc_bus.ready);
    if ($urandom_range(1, 100) <= gap_pct) begin
      acc_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  // Hold the sender until every pending result has been taken.
  task automatic settle();
    acc_bus.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_config(int unsigned set_v, int unsigned blk_v, int unsigned ways_v);
    settle();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= REG_SET_BITS;
    cfg_bus.data  <= {4'($urandom), 4'(set_v)};
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.index <= REG_BLOCK_BITS;
    cfg_bus.data  <= {3'($urandom), 5'(blk_v)};
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.index <= REG_WAYS;
    cfg_bus.data  <= {4'($urandom), 4'(ways_v)};
    do @(posedge clk_i); while (!cfg_bus.ready);
    if ($urandom_range(0, 3) == 0) begin
      cfg_bus.index <= REG_NONE;
      cfg_bus.data  <= 8'($urandom);
      do @(posedge clk_i); while (!cfg_bus.ready);
    end
    cfg_bus.valid <= 1'b0;
    cur_set  = set_v;
    cur_blk  = blk_v;
    cur_ways = ways_v;
  endtask

  initial begin : stimulus
    cmd_e cmd_pool[3];
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] tag;
    logic [ADDR_W-1:0] set_idx;
    int unsigned s_eff, nw, sh;

    cmd_pool        = '{CMD_LOAD, CMD_STORE, CMD_MODIFY};
    rst_ni          = 1'b0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.index   = REG_SET_BITS;
    cfg_bus.data    = '0;
    acc_bus.valid   = 1'b0;
    acc_bus.command = CMD_LOAD;
    acc_bus.address = '0;
    res_bus.ready   = 1'b0;
    stall_left      = 0;
    idle_cycles     = 0;
    gap_pct         = 10;
    stall_pct       = 10;
    cur_set         = SET_BITS_RST;
    cur_blk         = BLOCK_BITS_RST;
    cur_ways        = WAYS_RST;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset layout: direct mapped, 16 sets of 16-byte blocks
    send_access(CMD_LOAD, 64'h0);
    send_access(CMD_LOAD, 64'h8);
    send_access(CMD_STORE, 64'h10);
    send_access(CMD_MODIFY, 64'h1f);
    send_access(CMD_LOAD, 64'h100);
    send_access(CMD_UNKNOWN, 64'h104);
    send_access(CMD_MODIFY, '1);
    send_access(CMD_STORE, 64'h8000_0000_0000_0000);

    // one set, two ways, byte blocks: walk the recency order
    write_config(0, 0, 2);
    send_access(CMD_LOAD, 64'd1);
    send_access(CMD_LOAD, 64'd2);
    send_access(CMD_STORE, 64'd3);
    send_access(CMD_LOAD, 64'd2);
    send_access(CMD_MODIFY, 64'd1);
    send_access(CMD_MODIFY, 64'd3);

    // oversized fields clamp to 256 sets and 8 ways; fill a set, then evict
    write_config(15, 31, 15);
    for (int unsigned i = 0; i < 9; i++) begin
      send_access(cmd_pool[i % 3],
                  (ADDR_W'(i) << 39) | (ADDR_W'($urandom) & ADDR_W'(32'h7fff_ffff)));
    end
    send_access(CMD_LOAD, ADDR_W'(1) << 39);

    for (int unsigned p = 0; p < PHASES; p++) begin
      if (p == 0) write_config(8, 31, 8);
      else if (p == 1) write_config(0, 0, 0);
      else if (p == PHASES - 1) write_config(8, 0, 8);
      else write_config($urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 15));
      if (p == PHASES - 1) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      end
      s_eff = (cur_set > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : cur_set;
      nw    = (cur_ways == 0) ? 1 : ((cur_ways > MAX_WAYS_DEF) ? MAX_WAYS_DEF : cur_ways);
      sh    = cur_blk + s_eff;
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        cmd = ($urandom_range(0, 15) == 0) ? CMD_UNKNOWN : cmd_pool[$urandom_range(0, 2)];
        if ($urandom_range(0, 9) == 0) begin
          addr = {$urandom, $urandom};
        end else begin
          // few tags over few sets so lines get reused and evicted
          tag = $urandom_range(0, nw + 2);
          if ($urandom_range(0, 15) == 0) tag = {$urandom, $urandom};
          set_idx = $urandom_range(0, 3);
          addr = (tag << sh) | ((set_idx & ((ADDR_W'(1) << s_eff) - 1)) << cur_blk) |
                 ({$urandom, $urandom} & ((ADDR_W'(1) << cur_blk) - 1));
        end
        send_access(cmd, addr);
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/slc_pkg.sv
design/slc_if.sv
design/slc_front.sv
design/slc_back.sv
design/set_assoc_lru_cache_sim_top.sv
bench/slc_checker.sv
bench/tb.sv
